// ===== sv/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and codes of the request handshake controller
// Event codes, result codes, register indexes and the beat structs that
// travel between the configuration block, the core and the top level.
// ----------------------------------------------------------------------------
package rhc_pkg;

  // Event codes on cmd
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_FRAME   = 3'd1;
  localparam logic [2:0] CMD_RX_TO   = 3'd2;
  localparam logic [2:0] CMD_TX_DONE = 3'd3;
  localparam logic [2:0] CMD_TX_TO   = 3'd4;

  // Result action codes
  localparam logic [1:0] ACT_RECEIVE = 2'd0;
  localparam logic [1:0] ACT_SEND    = 2'd1;
  localparam logic [1:0] ACT_DONE    = 2'd2;

  // Outcome codes of a finished request
  localparam logic [1:0] OUT_OK         = 2'd0;
  localparam logic [1:0] OUT_BUSY       = 2'd1;
  localparam logic [1:0] OUT_TX_TIMEOUT = 2'd2;
  localparam logic [1:0] OUT_RX_TIMEOUT = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_OWN_ID       = 3'd0;
  localparam logic [2:0] REG_SEND_LIMIT   = 3'd1;
  localparam logic [2:0] REG_REPLY_LIMIT  = 3'd2;
  localparam logic [2:0] REG_LISTEN_TIME  = 3'd3;
  localparam logic [2:0] REG_REPLY_TIME   = 3'd4;
  localparam logic [2:0] REG_CALIB_MARKER = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_OWN_ID       = 16'h10AF;
  localparam logic [3:0]  RST_SEND_LIMIT   = 4'h3;
  localparam logic [3:0]  RST_REPLY_LIMIT  = 4'h3;
  localparam logic [23:0] RST_LISTEN_TIME  = 24'd5000000;
  localparam logic [23:0] RST_REPLY_TIME   = 24'd2000000;
  localparam logic [7:0]  RST_CALIB_MARKER = 8'h06;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef struct packed {
    logic [15:0] own_id;
    logic [3:0]  send_limit;
    logic [3:0]  reply_limit;
    logic [23:0] listen_time;
    logic [23:0] reply_time;
    logic [7:0]  calib_marker;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  batt_enable;
    logic [7:0]  battery_level;
    logic [15:0] frame_id;
    logic [7:0]  frame_code;
  } item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [23:0] wait_us;
    logic [15:0] packet_id;
    logic [7:0]  packet_enable;
    logic [7:0]  packet_level;
    logic [1:0]  outcome;
    logic        calibrate;
  } result_t;

endpackage

// ===== sv/request_handshake_controller.sv =====
// ----------------------------------------------------------------------------
// request_handshake_controller: listen-before-talk request handshake
// Event beat register, phase machine, result beat register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------
//   in      | input     | in_valid/in_ready  | cmd, batt_enable, ... frame_code
//   out     | output    | out_valid/out_ready| action ... calibrate
//   cfg     | input     | cfg_we (no wait)   | cfg_addr, cfg_data
//
// One event beat per cycle while results are not stalled. A taken event waits
// in the event beat register while the core updates its phase; its result, if any,
// goes to the result beat register. Reset clears phase, counters and both valid flags.
// A stalled result holds the event register, which in turn drops in_ready.
// ----------------------------------------------------------------------------
module request_handshake_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     cmd,
  input  logic [7:0]                     batt_enable,
  input  logic [7:0]                     battery_level,
  input  logic [15:0]                    frame_id,
  input  logic [7:0]                     frame_code,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     action,
  output logic [23:0]                    wait_us,
  output logic [15:0]                    packet_id,
  output logic [7:0]                     packet_enable,
  output logic [7:0]                     packet_level,
  output logic [1:0]                     outcome,
  output logic                           calibrate,
  input  logic                           cfg_we,
  input  logic [rhc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rhc_pkg::CFG_DATA_W-1:0] cfg_data
);

  rhc_pkg::cfg_t    cfg;
  rhc_pkg::item_t   item;
  rhc_pkg::result_t res;
  rhc_pkg::result_t out_res;
  logic             item_valid;
  logic             out_free;
  logic             go;
  logic             has_res;

  rhc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // Advance the event beat when the result register can take it
  assign out_free = !out_valid || out_ready;
  assign go       = item_valid && out_free;
  assign in_ready = !item_valid || out_free;

  // Event beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.cmd           <= cmd;
      item.batt_enable   <= batt_enable;
      item.battery_level <= battery_level;
      item.frame_id      <= frame_id;
      item.frame_code    <= frame_code;
    end
  end

  rhc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .item    (item),
    .cfg     (cfg),
    .has_res (has_res),
    .res     (res)
  );

  // Result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= go && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (go && has_res) begin
      out_res <= res;
    end
  end

  assign action        = out_res.action;
  assign wait_us       = out_res.wait_us;
  assign packet_id     = out_res.packet_id;
  assign packet_enable = out_res.packet_enable;
  assign packet_level  = out_res.packet_level;
  assign outcome       = out_res.outcome;
  assign calibrate     = out_res.calibrate;

  // A start event always yields a receive beat next cycle
  a_start_receive: assert property (@(posedge clk) disable iff (rst)
    go && item.cmd == rhc_pkg::CMD_START |=> out_valid && action == rhc_pkg::ACT_RECEIVE)
    else $error("start event did not yield a receive beat");

  // Calibration is flagged only on a successful finish
  a_calib_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibrate |-> action == rhc_pkg::ACT_DONE && outcome == rhc_pkg::OUT_OK)
    else $error("calibrate set outside a successful finish");

  // Only receive beats carry a wait time
  a_wait_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != rhc_pkg::ACT_RECEIVE |-> wait_us == '0)
    else $error("wait time on a non-receive beat");

  // An event beat is never dropped while the result side is stalled
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !out_free |=> item_valid && $stable(item))
    else $error("event beat lost under stall");

endmodule

// ===== sv/rhc_cfg.sv =====
// ----------------------------------------------------------------------------
// rhc_cfg: configuration registers
// Write-only register bank; indexes beyond the list are dropped.
// ----------------------------------------------------------------------------
module rhc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rhc_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [rhc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output rhc_pkg::cfg_t                     cfg
);

  // Load reset values, then take writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_id       <= rhc_pkg::RST_OWN_ID;
      cfg.send_limit   <= rhc_pkg::RST_SEND_LIMIT;
      cfg.reply_limit  <= rhc_pkg::RST_REPLY_LIMIT;
      cfg.listen_time  <= rhc_pkg::RST_LISTEN_TIME;
      cfg.reply_time   <= rhc_pkg::RST_REPLY_TIME;
      cfg.calib_marker <= rhc_pkg::RST_CALIB_MARKER;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rhc_pkg::REG_OWN_ID:       cfg.own_id       <= cfg_data[15:0];
        rhc_pkg::REG_SEND_LIMIT:   cfg.send_limit   <= cfg_data[3:0];
        rhc_pkg::REG_REPLY_LIMIT:  cfg.reply_limit  <= cfg_data[3:0];
        rhc_pkg::REG_LISTEN_TIME:  cfg.listen_time  <= cfg_data[23:0];
        rhc_pkg::REG_REPLY_TIME:   cfg.reply_time   <= cfg_data[23:0];
        rhc_pkg::REG_CALIB_MARKER: cfg.calib_marker <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/rhc_core.sv =====
// ----------------------------------------------------------------------------
// rhc_core: request phase machine
// Holds phase, retry counters and battery bytes; turns one event beat into
// at most one result beat combinationally.
// ----------------------------------------------------------------------------
module rhc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  rhc_pkg::item_t    item,
  input  rhc_pkg::cfg_t     cfg,
  output logic              has_res,
  output rhc_pkg::result_t  res
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LISTEN  = 2'd1,
    PH_SENDING = 2'd2,
    PH_REPLY   = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  send_retries, send_retries_next;
  logic [3:0]  reply_retries, reply_retries_next;
  logic [7:0]  held_enable, held_enable_next;
  logic [7:0]  held_level, held_level_next;

  rhc_pkg::result_t send_res;

  // Request packet built from own ID and the held battery bytes
  always_comb begin
    send_res               = '0;
    send_res.action        = rhc_pkg::ACT_SEND;
    send_res.packet_id     = cfg.own_id;
    send_res.packet_enable = held_enable;
    send_res.packet_level  = held_level;
  end

  // Decode the event against the current phase
  always_comb begin
    phase_next         = phase;
    send_retries_next  = send_retries;
    reply_retries_next = reply_retries;
    held_enable_next   = held_enable;
    held_level_next    = held_level;
    has_res            = 1'b0;
    res                = '0;
    unique case (item.cmd)
      rhc_pkg::CMD_START: begin
        held_enable_next   = item.batt_enable;
        held_level_next    = item.battery_level;
        send_retries_next  = '0;
        reply_retries_next = '0;
        phase_next         = PH_LISTEN;
        has_res            = 1'b1;
        res.action         = rhc_pkg::ACT_RECEIVE;
        res.wait_us        = cfg.listen_time;
      end
      rhc_pkg::CMD_FRAME: begin
        if (phase == PH_LISTEN) begin
          phase_next  = PH_IDLE;
          has_res     = 1'b1;
          res.action  = rhc_pkg::ACT_DONE;
          res.outcome = rhc_pkg::OUT_BUSY;
        end else if (phase == PH_REPLY) begin
          phase_next = PH_IDLE;
          has_res    = 1'b1;
          res.action = rhc_pkg::ACT_DONE;
          if (item.frame_id == cfg.own_id) begin
            res.outcome   = rhc_pkg::OUT_OK;
            res.calibrate = (item.frame_code == cfg.calib_marker);
          end else begin
            res.outcome = rhc_pkg::OUT_BUSY;
          end
        end
      end
      rhc_pkg::CMD_RX_TO: begin
        if (phase == PH_LISTEN) begin
          phase_next = PH_SENDING;
          has_res    = 1'b1;
          res        = send_res;
        end else if (phase == PH_REPLY) begin
          has_res = 1'b1;
          if (reply_retries < cfg.reply_limit) begin
            reply_retries_next = reply_retries + 4'd1;
            phase_next         = PH_SENDING;
            res                = send_res;
          end else begin
            phase_next  = PH_IDLE;
            res.action  = rhc_pkg::ACT_DONE;
            res.outcome = rhc_pkg::OUT_RX_TIMEOUT;
          end
        end
      end
      rhc_pkg::CMD_TX_DONE: begin
        if (phase == PH_SENDING) begin
          phase_next  = PH_REPLY;
          has_res     = 1'b1;
          res.action  = rhc_pkg::ACT_RECEIVE;
          res.wait_us = cfg.reply_time;
        end
      end
      rhc_pkg::CMD_TX_TO: begin
        if (phase == PH_SENDING) begin
          has_res = 1'b1;
          if (send_retries < cfg.send_limit) begin
            send_retries_next = send_retries + 4'd1;
            res               = send_res;
          end else begin
            phase_next  = PH_IDLE;
            res.action  = rhc_pkg::ACT_DONE;
            res.outcome = rhc_pkg::OUT_TX_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  // Advance state only when the event beat moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      send_retries  <= '0;
      reply_retries <= '0;
      held_enable   <= '0;
      held_level    <= '0;
    end else if (go) begin
      phase         <= phase_next;
      send_retries  <= send_retries_next;
      reply_retries <= reply_retries_next;
      held_enable   <= held_enable_next;
      held_level    <= held_level_next;
    end
  end

endmodule

// ===== dv/request_handshake_checker.sv =====
// ----------------------------------------------------------------------------
// request_handshake_checker: prediction and comparison of result beats
// Watches the event, result and register ports of the request handshake
// controller, replays every accepted event beat through its own copy of the
// request phase machine and compares each result beat field by field with
// the oldest pending prediction.
// ----------------------------------------------------------------------------
module request_handshake_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [2:0]                     cmd,
  input  logic [7:0]                     batt_enable,
  input  logic [7:0]                     battery_level,
  input  logic [15:0]                    frame_id,
  input  logic [7:0]                     frame_code,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [1:0]                     action,
  input  logic [23:0]                    wait_us,
  input  logic [15:0]                    packet_id,
  input  logic [7:0]                     packet_enable,
  input  logic [7:0]                     packet_level,
  input  logic [1:0]                     outcome,
  input  logic                           calibrate,
  input  logic                           cfg_we,
  input  logic [rhc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rhc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);

  typedef enum logic [1:0] {
    REQ_IDLE,
    REQ_LISTEN,
    REQ_SENDING,
    REQ_AWAIT_REPLY
  } req_phase_t;

  rhc_pkg::cfg_t    regs;
  req_phase_t       req_phase;
  logic [3:0]       tx_retries;
  logic [3:0]       rx_retries;
  logic [7:0]       latched_enable;
  logic [7:0]       latched_level;
  rhc_pkg::result_t predicted_results[$];

  // Build a finished-request beat and drop back to idle
  function automatic rhc_pkg::result_t finish_request(input logic [1:0] code,
                                                      input logic cal);
    rhc_pkg::result_t res;
    res         = '0;
    res.action  = rhc_pkg::ACT_DONE;
    res.outcome = code;
    res.calibrate = cal;
    req_phase   = REQ_IDLE;
    return res;
  endfunction

  function automatic rhc_pkg::result_t request_packet();
    rhc_pkg::result_t res;
    res               = '0;
    res.action        = rhc_pkg::ACT_SEND;
    res.packet_id     = regs.own_id;
    res.packet_enable = latched_enable;
    res.packet_level  = latched_level;
    return res;
  endfunction

  function automatic rhc_pkg::result_t listen_for(input logic [23:0] span);
    rhc_pkg::result_t res;
    res         = '0;
    res.action  = rhc_pkg::ACT_RECEIVE;
    res.wait_us = span;
    return res;
  endfunction

  // Advance the request phase machine by one event; return 1 with a beat
  function automatic bit advance_request(input rhc_pkg::item_t ev,
                                         output rhc_pkg::result_t res);
    bit produced;
    produced = 1'b0;
    res      = '0;
    case (ev.cmd)
      rhc_pkg::CMD_START: begin
        latched_enable = ev.batt_enable;
        latched_level  = ev.battery_level;
        tx_retries     = '0;
        rx_retries     = '0;
        req_phase      = REQ_LISTEN;
        res            = listen_for(regs.listen_time);
        produced       = 1'b1;
      end
      rhc_pkg::CMD_FRAME: begin
        if (req_phase == REQ_LISTEN) begin
          res      = finish_request(rhc_pkg::OUT_BUSY, 1'b0);
          produced = 1'b1;
        end else if (req_phase == REQ_AWAIT_REPLY) begin
          if (ev.frame_id == regs.own_id)
            res = finish_request(rhc_pkg::OUT_OK, ev.frame_code == regs.calib_marker);
          else
            res = finish_request(rhc_pkg::OUT_BUSY, 1'b0);
          produced = 1'b1;
        end
      end
      rhc_pkg::CMD_RX_TO: begin
        if (req_phase == REQ_LISTEN) begin
          req_phase = REQ_SENDING;
          res       = request_packet();
          produced  = 1'b1;
        end else if (req_phase == REQ_AWAIT_REPLY) begin
          if (rx_retries < regs.reply_limit) begin
            rx_retries = rx_retries + 4'd1;
            req_phase  = REQ_SENDING;
            res        = request_packet();
          end else begin
            res = finish_request(rhc_pkg::OUT_RX_TIMEOUT, 1'b0);
          end
          produced = 1'b1;
        end
      end
      rhc_pkg::CMD_TX_DONE: begin
        if (req_phase == REQ_SENDING) begin
          req_phase = REQ_AWAIT_REPLY;
          res       = listen_for(regs.reply_time);
          produced  = 1'b1;
        end
      end
      rhc_pkg::CMD_TX_TO: begin
        if (req_phase == REQ_SENDING) begin
          if (tx_retries < regs.send_limit) begin
            tx_retries = tx_retries + 4'd1;
            res        = request_packet();
          end else begin
            res = finish_request(rhc_pkg::OUT_TX_TIMEOUT, 1'b0);
          end
          produced = 1'b1;
        end
      end
      default: ;
    endcase
    return produced;
  endfunction

  task automatic check_field(input string field, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    rhc_pkg::item_t   ev;
    rhc_pkg::result_t res;
    rhc_pkg::result_t want;
    if (rst) begin
      regs.own_id       = rhc_pkg::RST_OWN_ID;
      regs.send_limit   = rhc_pkg::RST_SEND_LIMIT;
      regs.reply_limit  = rhc_pkg::RST_REPLY_LIMIT;
      regs.listen_time  = rhc_pkg::RST_LISTEN_TIME;
      regs.reply_time   = rhc_pkg::RST_REPLY_TIME;
      regs.calib_marker = rhc_pkg::RST_CALIB_MARKER;
      req_phase      = REQ_IDLE;
      tx_retries     = '0;
      rx_retries     = '0;
      latched_enable = '0;
      latched_level  = '0;
      predicted_results.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_addr)
          rhc_pkg::REG_OWN_ID:       regs.own_id       = cfg_data[15:0];
          rhc_pkg::REG_SEND_LIMIT:   regs.send_limit   = cfg_data[3:0];
          rhc_pkg::REG_REPLY_LIMIT:  regs.reply_limit  = cfg_data[3:0];
          rhc_pkg::REG_LISTEN_TIME:  regs.listen_time  = cfg_data;
          rhc_pkg::REG_REPLY_TIME:   regs.reply_time   = cfg_data;
          rhc_pkg::REG_CALIB_MARKER: regs.calib_marker = cfg_data[7:0];
          default: ;
        endcase
      end
      // Predict from each accepted event beat
      if (in_valid && in_ready) begin
        ev.cmd           = cmd;
        ev.batt_enable   = batt_enable;
        ev.battery_level = battery_level;
        ev.frame_id      = frame_id;
        ev.frame_code    = frame_code;
        if (advance_request(ev, res))
          predicted_results.push_back(res);
      end
      // Compare each accepted result beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result beat with no prediction pending: action %0d", action);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("action", 24'(want.action), 24'(action));
          check_field("wait_us", want.wait_us, wait_us);
          check_field("packet_id", 24'(want.packet_id), 24'(packet_id));
          check_field("packet_enable", 24'(want.packet_enable), 24'(packet_enable));
          check_field("packet_level", 24'(want.packet_level), 24'(packet_level));
          check_field("outcome", 24'(want.outcome), 24'(outcome));
          check_field("calibrate", 24'(want.calibrate), 24'(calibrate));
        end
      end
    end
    outstanding <= predicted_results.size();
  end

endmodule

// ===== dv/tb_request_handshake_controller.sv =====
// ----------------------------------------------------------------------------
// tb_request_handshake_controller: testbench top of the request controller
// Drives a directed pass over ignored events, every outcome, restarts and
// zero retry limits, then random request sequences with stray beats under
// several register settings, random idling on both sides and one long
// receiver hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_request_handshake_controller;

  localparam logic [2:0] CMD_UNUSED     = 3'd7;
  localparam int         IDLE_PCT       = 10;
  localparam int         SEND_GAP_PCT   = 5;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         RANDOM_PHASES  = 8;
  localparam int         BEATS_PER_PHASE = 210;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [2:0]                     cmd = '0;
  logic [7:0]                     batt_enable = '0;
  logic [7:0]                     battery_level = '0;
  logic [15:0]                    frame_id = '0;
  logic [7:0]                     frame_code = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     action;
  logic [23:0]                    wait_us;
  logic [15:0]                    packet_id;
  logic [7:0]                     packet_enable;
  logic [7:0]                     packet_level;
  logic [1:0]                     outcome;
  logic                           calibrate;
  logic                           cfg_we = 1'b0;
  logic [rhc_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [rhc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                             mismatches;
  int                             outstanding;

  rhc_pkg::cfg_t active_cfg;
  bit   quiet = 1'b0;
  bit   hold_off = 1'b0;
  int   request_beats = 0;
  int   stuck_cycles = 0;

  request_handshake_controller i_dut (.*);

  request_handshake_checker i_checker (.*);

  always #4 clk = ~clk;

  // Offer one event beat and hold it until accepted
  task automatic send_event(input logic [2:0] c, input logic [7:0] en,
                            input logic [7:0] lvl, input logic [15:0] fid,
                            input logic [7:0] code);
    if (!quiet && $urandom_range(99) < SEND_GAP_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= c;
    batt_enable   <= en;
    battery_level <= lvl;
    frame_id      <= fid;
    frame_code    <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send one well-formed beat, sometimes behind a stray one
  task automatic drive(input logic [2:0] c, input logic [15:0] fid,
                       input logic [7:0] code);
    if ($urandom_range(99) < 12)
      send_event(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                 16'($urandom), 8'($urandom));
    send_event(c, 8'($urandom), 8'($urandom), fid, code);
    request_beats++;
  endtask

  task automatic write_reg(input logic [rhc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rhc_pkg::CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic load_config(input rhc_pkg::cfg_t c);
    write_reg(rhc_pkg::REG_OWN_ID, {8'($urandom), c.own_id});
    write_reg(rhc_pkg::REG_SEND_LIMIT, {20'($urandom), c.send_limit});
    write_reg(rhc_pkg::REG_REPLY_LIMIT, {20'($urandom), c.reply_limit});
    write_reg(rhc_pkg::REG_LISTEN_TIME, c.listen_time);
    write_reg(rhc_pkg::REG_REPLY_TIME, c.reply_time);
    write_reg(rhc_pkg::REG_CALIB_MARKER, {16'($urandom), c.calib_marker});
    cfg_we     <= 1'b0;
    active_cfg = c;
  endtask

  // Drain: no beat offered, every prediction met, in-flight ignored beats gone
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic rhc_pkg::cfg_t pick_config(input int p);
    rhc_pkg::cfg_t c;
    c.own_id       = 16'($urandom);
    c.send_limit   = ($urandom_range(4) == 0) ? 4'hF : 4'($urandom_range(0, 3));
    c.reply_limit  = ($urandom_range(4) == 0) ? 4'hF : 4'($urandom_range(0, 3));
    c.listen_time  = 24'($urandom);
    c.reply_time   = 24'($urandom);
    c.calib_marker = 8'($urandom);
    if (p == 0)
      c = '0;
    else if (p == 1)
      c = '1;
    return c;
  endfunction

  // One request: start, listen, sends with timeouts, then a reply, timeout or abandon
  task automatic make_request();
    int tx_used;
    int rx_used;
    int pick;
    bit open;
    tx_used = 0;
    rx_used = 0;
    open    = 1'b1;
    drive(rhc_pkg::CMD_START, 16'($urandom), 8'($urandom));
    if ($urandom_range(99) < 10) begin
      drive(rhc_pkg::CMD_FRAME, 16'($urandom), 8'($urandom));
      return;
    end
    drive(rhc_pkg::CMD_RX_TO, 16'($urandom), 8'($urandom));
    while (open) begin
      while (open && $urandom_range(99) < 30) begin
        drive(rhc_pkg::CMD_TX_TO, 16'($urandom), 8'($urandom));
        tx_used++;
        if (tx_used > active_cfg.send_limit) open = 1'b0;
      end
      if (open) begin
        drive(rhc_pkg::CMD_TX_DONE, 16'($urandom), 8'($urandom));
        pick = $urandom_range(99);
        if (pick < 35) begin
          drive(rhc_pkg::CMD_FRAME, active_cfg.own_id,
                (pick < 17) ? active_cfg.calib_marker : 8'($urandom));
          open = 1'b0;
        end else if (pick < 50) begin
          drive(rhc_pkg::CMD_FRAME, 16'($urandom), 8'($urandom));
          open = 1'b0;
        end else if (pick < 55) begin
          // abandon; the next start aborts the request
          open = 1'b0;
        end else begin
          drive(rhc_pkg::CMD_RX_TO, 16'($urandom), 8'($urandom));
          rx_used++;
          if (rx_used > active_cfg.reply_limit) open = 1'b0;
        end
      end
    end
  endtask

  // Result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    active_cfg = '{own_id: rhc_pkg::RST_OWN_ID, send_limit: rhc_pkg::RST_SEND_LIMIT,
                   reply_limit: rhc_pkg::RST_REPLY_LIMIT,
                   listen_time: rhc_pkg::RST_LISTEN_TIME,
                   reply_time: rhc_pkg::RST_REPLY_TIME,
                   calib_marker: rhc_pkg::RST_CALIB_MARKER};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Events that idle does not expect, and an unused code
    send_event(rhc_pkg::CMD_FRAME, 8'h00, 8'h00, 16'hFFFF, 8'hFF);
    send_event(rhc_pkg::CMD_TX_DONE, 8'hFF, 8'hFF, 16'h0000, 8'h00);
    send_event(CMD_UNUSED, 8'h5A, 8'hA5, 16'h10AF, 8'h06);
    // Busy channel while listening
    send_event(rhc_pkg::CMD_START, 8'hFF, 8'h00, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_FRAME, 8'h00, 8'h00, 16'h1234, 8'h00);
    // Transmit timeouts up to the limit and past it
    send_event(rhc_pkg::CMD_START, 8'h00, 8'hFF, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_RX_TO, 8'h00, 8'h00, 16'h0000, 8'h00);
    repeat (4) send_event(rhc_pkg::CMD_TX_TO, 8'h00, 8'h00, 16'h0000, 8'h00);
    // Grant for own ID with the calibration code
    send_event(rhc_pkg::CMD_START, 8'hA5, 8'h5A, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_RX_TO, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_TX_DONE, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_FRAME, 8'h00, 8'h00, rhc_pkg::RST_OWN_ID,
               rhc_pkg::RST_CALIB_MARKER);
    // Grant for another ID
    send_event(rhc_pkg::CMD_START, 8'h3C, 8'hC3, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_RX_TO, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_TX_DONE, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_FRAME, 8'h00, 8'h00, ~rhc_pkg::RST_OWN_ID, 8'h00);
    // Leave a request waiting on a resend, then change registers under it
    send_event(rhc_pkg::CMD_START, 8'h11, 8'h22, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_RX_TO, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_TX_DONE, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_RX_TO, 8'h00, 8'h00, 16'h0000, 8'h00);
    settle();
    load_config('{own_id: 16'hFFFF, send_limit: 4'h0, reply_limit: 4'h0,
                  listen_time: 24'h000000, reply_time: 24'hFFFFFF,
                  calib_marker: 8'hFF});
    // Zero limits end the request on the first timeout of each kind
    send_event(rhc_pkg::CMD_TX_TO, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_START, 8'hFF, 8'hFF, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_RX_TO, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_TX_DONE, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_RX_TO, 8'h00, 8'h00, 16'h0000, 8'h00);
    // Restart during a request, then grant with all-ones ID and code
    send_event(rhc_pkg::CMD_START, 8'h01, 8'h80, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_START, 8'h80, 8'h01, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_RX_TO, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_TX_DONE, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_event(rhc_pkg::CMD_FRAME, 8'h00, 8'h00, 16'hFFFF, 8'hFF);

    // Random requests under a fresh register set per phase
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      load_config(pick_config(p));
      quiet = (p == 2);
      if (p == 4) hold_off = 1'b1;
      while (request_beats < (p + 1) * BEATS_PER_PHASE) make_request();
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
